/* hw/rtl/qkc_pkg.sv */
// Shared package of the quadratic knee soft clipper: constants, types and Q31 arithmetic.
// Used by qkc_coef, quadratic_knee_soft_clipper and the testbench; depends on nothing else.
package qkc_pkg;

    localparam int DATA_W    = 32;
    localparam int LIM_POS_W = 31;
    localparam int CFG_IDX_W = 2;
    localparam int DIV_STEPS = 31;
    localparam int DVS_W     = 12;
    localparam int D_SHIFT   = 24;
    localparam int Q_SHIFT   = 20;

    localparam logic [CFG_IDX_W-1:0] REG_CLIP_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_POS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_NEG = 2'd2;

    localparam logic [1:0] MODE_SYM  = 2'd0;
    localparam logic [1:0] MODE_ASYM = 2'd1;
    localparam logic [1:0] MODE_NORM = 2'd2;

    localparam logic signed [DATA_W-1:0] Q31_MAX       = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] Q31_MIN       = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] KNEE_BIAS     = 32'sh00FF_FFFF;
    localparam logic [LIM_POS_W-1:0]     LIM_POS_MAX   = 31'd2130706431;
    localparam logic signed [DATA_W-1:0] LIM_NEG_MIN   = -32'sd2130706431;
    localparam logic [LIM_POS_W-1:0]     RST_LIMIT_POS = 31'h4000_0000;
    localparam logic signed [DATA_W-1:0] RST_LIMIT_NEG = -32'sh4000_0000;

    localparam logic [3:0] SHL_KNEE      = 4'd7;
    localparam logic [3:0] SHL_NORM_KNEE = 4'd11;
    localparam logic [3:0] SHL_NORM_LIN  = 4'd4;

    typedef struct packed {
        logic signed [DATA_W-1:0] a;
        logic signed [DATA_W-1:0] b;
        logic signed [DATA_W-1:0] c;
    } qkc_coef_t;

    typedef struct packed {
        logic                     busy;
        logic [1:0]               mode;
        logic [LIM_POS_W-1:0]     lim_pos;
        logic signed [DATA_W-1:0] lim_neg;
        qkc_coef_t                coef_p;
        qkc_coef_t                coef_n;
        logic signed [DATA_W-1:0] norm;
    } qkc_ctl_t;

    typedef enum logic [3:0] {
        SEQ_START,
        SEQ_DIV_B,
        SEQ_COEF_AB,
        SEQ_MUL_A,
        SEQ_SUB_U,
        SEQ_MUL_C,
        SEQ_STORE,
        SEQ_SUM,
        SEQ_DIV_N,
        SEQ_NORM_FIN,
        SEQ_DONE
    } qkc_seq_t;

    function automatic logic signed [DATA_W-1:0] qmul(
        input logic signed [DATA_W-1:0] p,
        input logic signed [DATA_W-1:0] q
    );
        logic signed [2*DATA_W-1:0] prod;
        prod = p * q;
        if (p == Q31_MIN && q == Q31_MIN) begin
            return Q31_MAX;
        end
        return prod[2*DATA_W-2:DATA_W-1];
    endfunction

    function automatic logic signed [DATA_W-1:0] sat_add(
        input logic signed [DATA_W-1:0] p,
        input logic signed [DATA_W-1:0] q
    );
        logic signed [DATA_W:0] s;
        s = (DATA_W+1)'(p) + (DATA_W+1)'(q);
        if (s[DATA_W] != s[DATA_W-1]) begin
            return s[DATA_W] ? Q31_MIN : Q31_MAX;
        end
        return s[DATA_W-1:0];
    endfunction

    function automatic logic signed [DATA_W-1:0] sat_sub(
        input logic signed [DATA_W-1:0] p,
        input logic signed [DATA_W-1:0] q
    );
        logic signed [DATA_W:0] s;
        s = (DATA_W+1)'(p) - (DATA_W+1)'(q);
        if (s[DATA_W] != s[DATA_W-1]) begin
            return s[DATA_W] ? Q31_MIN : Q31_MAX;
        end
        return s[DATA_W-1:0];
    endfunction

    function automatic logic signed [DATA_W-1:0] sat_neg(
        input logic signed [DATA_W-1:0] p
    );
        return (p == Q31_MIN) ? Q31_MAX : -p;
    endfunction

    function automatic logic signed [DATA_W-1:0] sat_shl(
        input logic signed [DATA_W-1:0] p,
        input logic [3:0]               n
    );
        logic signed [2*DATA_W-1:0] w;
        w = (2*DATA_W)'(p) <<< n;
        if (w[2*DATA_W-1:DATA_W-1] != {(DATA_W+1){w[2*DATA_W-1]}}) begin
            return w[2*DATA_W-1] ? Q31_MIN : Q31_MAX;
        end
        return w[DATA_W-1:0];
    endfunction

endpackage

/* hw/rtl/qkc_coef.sv */
// Configuration registers and coefficient sequencer of the quadratic knee soft clipper.
// Derives a, b, c for both knees and the normalizing gain with a bit-serial divider.
// Depends on qkc_pkg.
module qkc_coef (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wen,
    input  logic [qkc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [qkc_pkg::DATA_W-1:0]       cfg_wdata,
    output qkc_pkg::qkc_ctl_t                ctl
);

    localparam int CNT_W = $clog2(qkc_pkg::DIV_STEPS);
    localparam int DW    = qkc_pkg::DATA_W;
    localparam int LW    = qkc_pkg::LIM_POS_W;
    localparam int VW    = qkc_pkg::DVS_W;

    qkc_pkg::qkc_seq_t state_reg;
    qkc_pkg::qkc_seq_t state_next;

    logic [1:0]           mode_reg;
    logic [LW-1:0]        lim_pos_reg;
    logic signed [DW-1:0] lim_neg_reg;
    logic                 set_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [VW-1:0]        dvs_reg;
    logic [VW-1:0]        rem_reg;
    logic [LW-1:0]        quo_reg;
    logic                 nneg_reg;
    logic signed [DW-1:0] a_reg;
    logic signed [DW-1:0] b_reg;
    logic signed [DW-1:0] c_reg;
    logic signed [DW-1:0] t_reg;
    logic signed [DW-1:0] u_reg;
    logic signed [DW-1:0] norm_reg;
    qkc_pkg::qkc_coef_t   coef_p_reg;
    qkc_pkg::qkc_coef_t   coef_n_reg;

    logic [LW-1:0]        wr_pos;
    logic signed [DW-1:0] wr_neg;
    logic signed [DW-1:0] lim;
    logic [LW-1:0]        gap;
    logic [LW-1:0]        gap_sh;
    logic [VW-1:0]        dvs_b;
    logic signed [DW+1:0] abc;
    logic signed [VW-1:0] qv;
    logic [VW-1:0]        q_abs;
    logic [VW:0]          trial;
    logic [VW:0]          diff;
    logic                 qbit;
    logic signed [DW-1:0] mul_op;
    logic signed [DW-1:0] mul_res;
    logic signed [DW+1:0] u_wide;

    logic busy;
    logic ld_div_b;
    logic ld_div_n;
    logic div_step;
    logic ld_ab;
    logic ld_t;
    logic ld_u;
    logic ld_c;
    logic st_coef;
    logic ld_norm;

    always_comb
    begin
        wr_pos = (cfg_wdata[LW-1:0] > qkc_pkg::LIM_POS_MAX) ? qkc_pkg::LIM_POS_MAX
                                                             : cfg_wdata[LW-1:0];
        wr_neg = $signed(cfg_wdata);
        if (wr_neg > 32'sd0)
        begin
            wr_neg = 32'sd0;
        end
        else if (wr_neg < qkc_pkg::LIM_NEG_MIN)
        begin
            wr_neg = qkc_pkg::LIM_NEG_MIN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= qkc_pkg::MODE_SYM;
            lim_pos_reg <= qkc_pkg::RST_LIMIT_POS;
            lim_neg_reg <= qkc_pkg::RST_LIMIT_NEG;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                qkc_pkg::REG_CLIP_MODE: mode_reg    <= cfg_wdata[1:0];
                qkc_pkg::REG_LIMIT_POS: lim_pos_reg <= wr_pos;
                qkc_pkg::REG_LIMIT_NEG: lim_neg_reg <= wr_neg;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        lim    = set_reg ? (32'sd0 - lim_neg_reg) : $signed({1'b0, lim_pos_reg});
        gap    = 31'h7FFF_FFFF - lim[LW-1:0];
        gap_sh = gap >> qkc_pkg::D_SHIFT;
        dvs_b  = gap_sh[VW-1:0];

        abc = (DW+2)'(a_reg) + (DW+2)'(b_reg) + (DW+2)'(c_reg);
        qv  = abc[DW-1:qkc_pkg::Q_SHIFT];
        if (qv[VW-1])
        begin
            q_abs = VW'(-qv);
        end
        else if (qv == '0)
        begin
            q_abs = VW'(1);
        end
        else
        begin
            q_abs = qv;
        end

        trial = {rem_reg, 1'b1};
        diff  = trial - {1'b0, dvs_reg};
        qbit  = !diff[VW];

        mul_op  = (state_reg == qkc_pkg::SEQ_MUL_A) ? a_reg : u_reg;
        mul_res = qkc_pkg::qmul(lim, mul_op);
        u_wide  = (DW+2)'(qkc_pkg::KNEE_BIAS) - (DW+2)'(b_reg) - (DW+2)'(t_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            qkc_pkg::SEQ_START:    state_next = qkc_pkg::SEQ_DIV_B;
            qkc_pkg::SEQ_DIV_B:
            begin
                if (cnt_reg == CNT_W'(qkc_pkg::DIV_STEPS - 1))
                begin
                    state_next = qkc_pkg::SEQ_COEF_AB;
                end
            end
            qkc_pkg::SEQ_COEF_AB:  state_next = qkc_pkg::SEQ_MUL_A;
            qkc_pkg::SEQ_MUL_A:    state_next = qkc_pkg::SEQ_SUB_U;
            qkc_pkg::SEQ_SUB_U:    state_next = qkc_pkg::SEQ_MUL_C;
            qkc_pkg::SEQ_MUL_C:    state_next = qkc_pkg::SEQ_STORE;
            qkc_pkg::SEQ_STORE:
                state_next = set_reg ? qkc_pkg::SEQ_DONE : qkc_pkg::SEQ_SUM;
            qkc_pkg::SEQ_SUM:      state_next = qkc_pkg::SEQ_DIV_N;
            qkc_pkg::SEQ_DIV_N:
            begin
                if (cnt_reg == CNT_W'(qkc_pkg::DIV_STEPS - 1))
                begin
                    state_next = qkc_pkg::SEQ_NORM_FIN;
                end
            end
            qkc_pkg::SEQ_NORM_FIN: state_next = qkc_pkg::SEQ_START;
            qkc_pkg::SEQ_DONE:     state_next = qkc_pkg::SEQ_DONE;
            default:               state_next = qkc_pkg::SEQ_START;
        endcase
        if (cfg_wen)
        begin
            state_next = qkc_pkg::SEQ_START;
        end
    end

    always_comb
    begin
        busy     = 1'b1;
        ld_div_b = 1'b0;
        ld_div_n = 1'b0;
        div_step = 1'b0;
        ld_ab    = 1'b0;
        ld_t     = 1'b0;
        ld_u     = 1'b0;
        ld_c     = 1'b0;
        st_coef  = 1'b0;
        ld_norm  = 1'b0;
        unique case (state_reg)
            qkc_pkg::SEQ_START:    ld_div_b = 1'b1;
            qkc_pkg::SEQ_DIV_B:    div_step = 1'b1;
            qkc_pkg::SEQ_COEF_AB:  ld_ab    = 1'b1;
            qkc_pkg::SEQ_MUL_A:    ld_t     = 1'b1;
            qkc_pkg::SEQ_SUB_U:    ld_u     = 1'b1;
            qkc_pkg::SEQ_MUL_C:    ld_c     = 1'b1;
            qkc_pkg::SEQ_STORE:    st_coef  = 1'b1;
            qkc_pkg::SEQ_SUM:      ld_div_n = 1'b1;
            qkc_pkg::SEQ_DIV_N:    div_step = 1'b1;
            qkc_pkg::SEQ_NORM_FIN: ld_norm  = 1'b1;
            qkc_pkg::SEQ_DONE:     busy     = 1'b0;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= qkc_pkg::SEQ_START;
            set_reg   <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wen)
            begin
                set_reg <= 1'b0;
            end
            else if (ld_norm)
            begin
                set_reg <= 1'b1;
            end
            if (ld_div_b || ld_div_n)
            begin
                cnt_reg <= '0;
            end
            else if (div_step)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld_div_b)
        begin
            dvs_reg <= dvs_b;
            rem_reg <= '0;
        end
        if (ld_div_n)
        begin
            dvs_reg  <= q_abs;
            rem_reg  <= '0;
            nneg_reg <= qv[VW-1];
        end
        if (div_step)
        begin
            rem_reg <= qbit ? diff[VW-1:0] : trial[VW-1:0];
            quo_reg <= {quo_reg[LW-2:0], qbit};
        end
        if (ld_ab)
        begin
            b_reg <= $signed({1'b0, quo_reg});
            a_reg <= 32'sd0 - $signed({2'b00, quo_reg[LW-1:1]});
        end
        if (ld_t)
        begin
            t_reg <= mul_res;
        end
        if (ld_u)
        begin
            u_reg <= u_wide[DW-1:0];
        end
        if (ld_c)
        begin
            c_reg <= mul_res;
        end
        if (st_coef)
        begin
            if (set_reg)
            begin
                coef_n_reg <= '{a: a_reg, b: b_reg, c: c_reg};
            end
            else
            begin
                coef_p_reg <= '{a: a_reg, b: b_reg, c: c_reg};
            end
        end
        if (ld_norm)
        begin
            norm_reg <= nneg_reg ? (32'sd0 - $signed({1'b0, quo_reg}))
                                 : $signed({1'b0, quo_reg});
        end
    end

    assign ctl.busy    = busy;
    assign ctl.mode    = mode_reg;
    assign ctl.lim_pos = lim_pos_reg;
    assign ctl.lim_neg = lim_neg_reg;
    assign ctl.coef_p  = coef_p_reg;
    assign ctl.coef_n  = coef_n_reg;
    assign ctl.norm    = norm_reg;

`ifndef NO_ASSERTIONS
    a_wr_restart: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wen |=> state_reg == qkc_pkg::SEQ_START)
        else $error("A register write did not restart the coefficient sequence.");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == qkc_pkg::SEQ_DIV_B || state_reg == qkc_pkg::SEQ_DIV_N)
        |-> dvs_reg != '0)
        else $error("The divider runs with a zero divisor.");

    a_lim_range: assert property (@(posedge clk) disable iff (!rst_n)
        lim_pos_reg <= qkc_pkg::LIM_POS_MAX && lim_neg_reg <= 32'sd0
        && lim_neg_reg >= qkc_pkg::LIM_NEG_MIN)
        else $error("A knee limit left its range.");

    a_coef_rel: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == qkc_pkg::SEQ_DONE
        |-> $signed(coef_p_reg.b) > 32'sd0
            && $signed(coef_p_reg.a) == 32'sd0 - ($signed(coef_p_reg.b) >>> 1))
        else $error("The positive knee coefficients are inconsistent.");
`endif

endmodule

/* hw/rtl/quadratic_knee_soft_clipper.sv */
// Top level of the quadratic knee soft clipper: six-stage sample pipeline with handshake.
// Depends on qkc_pkg and qkc_coef.
//
// Channel   Direction  Handshake                   Payload
// s_axis    in         s_axis_tvalid/s_axis_tready s_axis_tdata[31:0] = sample_in
// m_axis    out        m_axis_tvalid/m_axis_tready m_axis_tdata[31:0] = sample_out
// cfg       in         cfg_wen (no wait)           cfg_index[1:0], cfg_wdata[31:0]
//
// A sample passes six register stages from its s_axis transaction to its m_axis result,
// and a new sample can enter every cycle unless the sequencer is busy or stage 0 is held.
// After reset and after every register write the coefficient sequencer derives the
// coefficients with its bit-serial divider, and s_axis_tready stays low meanwhile.
// A stall on m_axis backs up stage by stage, so empty stages still take new samples.
module quadratic_knee_soft_clipper (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wen,
    input  logic [qkc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [qkc_pkg::DATA_W-1:0]    cfg_wdata,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [qkc_pkg::DATA_W-1:0]    s_axis_tdata,   // [31:0] sample_in
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [qkc_pkg::DATA_W-1:0]    m_axis_tdata    // [31:0] sample_out
);

    localparam int NSTG = 6;
    localparam int DW   = qkc_pkg::DATA_W;

    localparam logic [1:0] SIDE_LIN = 2'd0;
    localparam logic [1:0] SIDE_POS = 2'd1;
    localparam logic [1:0] SIDE_NEG = 2'd2;

    qkc_pkg::qkc_ctl_t ctl;

    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] stg_rdy;
    logic            in_fire;

    logic signed [DW-1:0] x_in;
    logic signed [DW-1:0] thr_pos;
    logic signed [DW-1:0] thr_neg;
    qkc_pkg::qkc_coef_t   coef_sel_n;
    logic [1:0]           side_in;
    logic signed [DW-1:0] a_in;
    logic signed [DW-1:0] b_in;
    logic signed [DW-1:0] c_in;

    logic signed [DW-1:0] x1_reg, x2_reg, x3_reg, x4_reg, x5_reg;
    logic [1:0]           side1_reg, side2_reg, side3_reg, side4_reg, side5_reg;
    logic signed [DW-1:0] a1_reg, b1_reg, c1_reg;
    logic signed [DW-1:0] a2_reg, c2_reg, xx2_reg, bx2_reg;
    logic signed [DW-1:0] axx3_reg, r3_reg;
    logic signed [DW-1:0] k4_reg;
    logic signed [DW-1:0] k5_reg, p5_reg;
    logic signed [DW-1:0] out_reg;
    logic signed [DW-1:0] y_next;

    qkc_coef u_coef (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .ctl       (ctl)
    );

    always_comb
    begin
        stg_rdy[NSTG-1] = !vld_reg[NSTG-1] || m_axis_tready;
        for (int k = NSTG - 2; k >= 0; k--)
        begin
            stg_rdy[k] = !vld_reg[k] || stg_rdy[k+1];
        end
    end

    assign s_axis_tready = stg_rdy[0] && !ctl.busy;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = vld_reg[NSTG-1];
    assign m_axis_tdata  = out_reg;

    always_comb
    begin
        x_in       = $signed(s_axis_tdata);
        thr_pos    = $signed({1'b0, ctl.lim_pos});
        thr_neg    = (ctl.mode == qkc_pkg::MODE_ASYM) ? ctl.lim_neg : -thr_pos;
        coef_sel_n = (ctl.mode == qkc_pkg::MODE_ASYM) ? ctl.coef_n : ctl.coef_p;
        side_in    = SIDE_LIN;
        a_in       = ctl.coef_p.a;
        b_in       = ctl.coef_p.b;
        c_in       = ctl.coef_p.c;
        if (x_in >= thr_pos)
        begin
            side_in = SIDE_POS;
        end
        else if (x_in <= thr_neg)
        begin
            side_in = SIDE_NEG;
            a_in    = coef_sel_n.a;
            b_in    = coef_sel_n.b;
            c_in    = qkc_pkg::sat_neg(coef_sel_n.c);
        end
    end

    always_comb
    begin
        if (ctl.mode == qkc_pkg::MODE_NORM)
        begin
            y_next = (side5_reg == SIDE_LIN) ? qkc_pkg::sat_shl(p5_reg, qkc_pkg::SHL_NORM_LIN)
                                             : qkc_pkg::sat_shl(p5_reg, qkc_pkg::SHL_NORM_KNEE);
        end
        else
        begin
            y_next = (side5_reg == SIDE_LIN) ? x5_reg
                                             : qkc_pkg::sat_shl(k5_reg, qkc_pkg::SHL_KNEE);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (stg_rdy[0])
            begin
                vld_reg[0] <= in_fire;
            end
            for (int k = 1; k < NSTG; k++)
            begin
                if (stg_rdy[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (stg_rdy[0])
        begin
            x1_reg    <= x_in;
            side1_reg <= side_in;
            a1_reg    <= a_in;
            b1_reg    <= b_in;
            c1_reg    <= c_in;
        end
        if (stg_rdy[1])
        begin
            x2_reg    <= x1_reg;
            side2_reg <= side1_reg;
            a2_reg    <= a1_reg;
            c2_reg    <= c1_reg;
            xx2_reg   <= qkc_pkg::qmul(x1_reg, x1_reg);
            bx2_reg   <= qkc_pkg::qmul(b1_reg, x1_reg);
        end
        if (stg_rdy[2])
        begin
            x3_reg    <= x2_reg;
            side3_reg <= side2_reg;
            axx3_reg  <= qkc_pkg::qmul(a2_reg, xx2_reg);
            r3_reg    <= qkc_pkg::sat_add(c2_reg, bx2_reg);
        end
        if (stg_rdy[3])
        begin
            x4_reg    <= x3_reg;
            side4_reg <= side3_reg;
            k4_reg    <= (side3_reg == SIDE_NEG) ? qkc_pkg::sat_sub(r3_reg, axx3_reg)
                                                 : qkc_pkg::sat_add(r3_reg, axx3_reg);
        end
        if (stg_rdy[4])
        begin
            x5_reg    <= x4_reg;
            side5_reg <= side4_reg;
            k5_reg    <= k4_reg;
            p5_reg    <= qkc_pkg::qmul((side4_reg == SIDE_LIN) ? x4_reg : k4_reg, ctl.norm);
        end
        if (stg_rdy[5])
        begin
            out_reg <= y_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_in_enters: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> vld_reg[0])
        else $error("An accepted transaction did not enter the first stage.");

    a_busy_block: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.busy |-> !(s_axis_tvalid && s_axis_tready))
        else $error("A sample was accepted while coefficients were being derived.");

    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[NSTG-2] && !stg_rdy[NSTG-2] |=> vld_reg[NSTG-2] && $stable(p5_reg))
        else $error("A stalled pipeline stage lost its contents.");
`endif

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for quadratic_knee_soft_clipper: directed table, then random samples.
// Depends on qkc_pkg and the RTL; typed values or a Q31 clipper predictor check every result.
module testbench;

    localparam longint FULL_POS       = 64'sd2147483647;
    localparam longint FULL_NEG       = -64'sd2147483648;
    localparam longint KNEE_POS_CEIL  = 64'sd2130706431;
    localparam longint KNEE_NEG_FLOOR = -64'sd2130706431;
    localparam logic [qkc_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam int DIR_ROWS    = 35;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 75;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 20;
    localparam int REPORT_MAX  = 10;

    typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

    typedef struct packed {
        row_kind_t                         kind;
        logic [qkc_pkg::CFG_IDX_W-1:0]     idx;
        logic [qkc_pkg::DATA_W-1:0]        data;
        logic                              typed;
        logic [qkc_pkg::DATA_W-1:0]        want;
    } dir_row_t;

    typedef struct packed {
        int a;
        int b;
        int c;
    } knee_coef_t;

    localparam dir_row_t DIRECTED_ROWS [DIR_ROWS] = '{
        '{ROW_SAMPLE, '0, 32'h0000_0000, 1'b1, 32'h0000_0000},
        '{ROW_SAMPLE, '0, 32'h1234_5678, 1'b1, 32'h1234_5678},
        '{ROW_SAMPLE, '0, 32'hC000_0001, 1'b1, 32'hC000_0001},
        '{ROW_SAMPLE, '0, 32'h4000_0000, 1'b0, '0},
        '{ROW_SAMPLE, '0, 32'h7FFF_FFFF, 1'b0, '0},
        '{ROW_SAMPLE, '0, 32'h8000_0000, 1'b0, '0},
        '{ROW_SAMPLE, '0, 32'hC000_0000, 1'b0, '0},
        '{ROW_WRITE, qkc_pkg::REG_CLIP_MODE, {30'd0, qkc_pkg::MODE_ASYM}, 1'b0, '0},
        '{ROW_WRITE, qkc_pkg::REG_LIMIT_NEG, 32'hE000_0000, 1'b0, '0},
        '{ROW_SAMPLE, '0, 32'hE000_0001, 1'b1, 32'hE000_0001},
        '{ROW_SAMPLE, '0, 32'hE000_0000, 1'b0, '0},
        '{ROW_SAMPLE, '0, 32'h8000_0000, 1'b0, '0},
        '{ROW_SAMPLE, '0, 32'h3FFF_FFFF, 1'b1, 32'h3FFF_FFFF},
        '{ROW_WRITE, qkc_pkg::REG_CLIP_MODE, {30'd0, qkc_pkg::MODE_NORM}, 1'b0, '0},
        '{ROW_SAMPLE, '0, 32'h0000_0000, 1'b1, 32'h0000_0000},
        '{ROW_SAMPLE, '0, 32'h1000_0000, 1'b0, '0},
        '{ROW_SAMPLE, '0, 32'h7FFF_FFFF, 1'b0, '0},
        '{ROW_SAMPLE, '0, 32'h8000_0000, 1'b0, '0},
        '{ROW_WRITE, qkc_pkg::REG_CLIP_MODE, {30'd0, MODE_SPARE}, 1'b0, '0},
        '{ROW_SAMPLE, '0, 32'h7FFF_FFFF, 1'b0, '0},
        '{ROW_WRITE, qkc_pkg::REG_LIMIT_POS, 32'h0000_0000, 1'b0, '0},
        '{ROW_SAMPLE, '0, 32'h0000_0000, 1'b0, '0},
        '{ROW_SAMPLE, '0, 32'hFFFF_FFFF, 1'b0, '0},
        '{ROW_SAMPLE, '0, 32'h0000_0001, 1'b0, '0},
        '{ROW_WRITE, qkc_pkg::REG_LIMIT_POS, 32'hFFFF_FFFF, 1'b0, '0},
        '{ROW_SAMPLE, '0, 32'h7F00_0000, 1'b0, '0},
        '{ROW_SAMPLE, '0, 32'h7EFF_FFFE, 1'b1, 32'h7EFF_FFFE},
        '{ROW_WRITE, qkc_pkg::REG_CLIP_MODE, {30'd0, qkc_pkg::MODE_ASYM}, 1'b0, '0},
        '{ROW_WRITE, qkc_pkg::REG_LIMIT_NEG, 32'h0000_0005, 1'b0, '0},
        '{ROW_SAMPLE, '0, 32'h0000_0000, 1'b0, '0},
        '{ROW_WRITE, qkc_pkg::REG_LIMIT_NEG, 32'h8000_0000, 1'b0, '0},
        '{ROW_SAMPLE, '0, 32'h8000_0000, 1'b0, '0},
        '{ROW_SAMPLE, '0, 32'h8100_0001, 1'b0, '0},
        '{ROW_WRITE, REG_UNUSED, 32'hFFFF_FFFF, 1'b0, '0},
        '{ROW_SAMPLE, '0, 32'h8100_0002, 1'b1, 32'h8100_0002}
    };

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              cfg_wen = 1'b0;
    logic [qkc_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
    logic [qkc_pkg::DATA_W-1:0]        cfg_wdata = '0;
    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    logic [qkc_pkg::DATA_W-1:0]        s_axis_tdata = '0;   // [31:0] sample_in
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    logic [qkc_pkg::DATA_W-1:0]        m_axis_tdata;        // [31:0] sample_out

    logic [1:0]                 pred_mode;
    int                         pred_lim_pos;
    int                         pred_lim_neg;
    logic [qkc_pkg::DATA_W-1:0] results_due [$];
    int                         burst_left = 0;
    int                         samples_sent = 0;
    int                         directed_sent = 0;
    int                         results_seen = 0;
    int                         reg_writes = 0;
    int                         mismatches = 0;
    logic                       hold_wanted = 1'b0;

    quadratic_knee_soft_clipper u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wen       (cfg_wen),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #6 clk = ~clk;

    function automatic int clamp32(longint v);
        if (v > FULL_POS) return int'(FULL_POS);
        if (v < FULL_NEG) return int'(FULL_NEG);
        return int'(v);
    endfunction

    function automatic int frac_mul(int p, int q);
        if (longint'(p) == FULL_NEG && longint'(q) == FULL_NEG) return int'(FULL_POS);
        return int'((longint'(p) * longint'(q)) >>> 31);
    endfunction

    function automatic int sat_plus(int p, int q);
        return clamp32(longint'(p) + longint'(q));
    endfunction

    function automatic int sat_minus(int p, int q);
        return clamp32(longint'(p) - longint'(q));
    endfunction

    function automatic int sat_negate(int p);
        return clamp32(-longint'(p));
    endfunction

    function automatic int sat_shift(int p, int n);
        return clamp32(longint'(p) <<< n);
    endfunction

    function automatic knee_coef_t derive_knee(int lim);
        knee_coef_t k;
        longint     d;
        d = (FULL_POS - longint'(lim)) >>> 24;
        if (d == 0) d = 1;
        k.b = int'(FULL_POS / d);
        k.a = sat_negate(k.b >>> 1);
        k.c = frac_mul(lim, int'((FULL_POS >>> 7) - longint'(k.b)
                                 - longint'(frac_mul(lim, k.a))));
        return k;
    endfunction

    function automatic int knee_up(knee_coef_t k, int x);
        int r;
        r = sat_plus(k.c, frac_mul(k.b, x));
        return sat_plus(r, frac_mul(k.a, frac_mul(x, x)));
    endfunction

    function automatic int knee_down(knee_coef_t k, int x);
        int r;
        r = sat_plus(sat_negate(k.c), frac_mul(k.b, x));
        return sat_minus(r, frac_mul(k.a, frac_mul(x, x)));
    endfunction

    function automatic logic [qkc_pkg::DATA_W-1:0] clip_sample(int x);
        knee_coef_t k;
        int         y;
        int         norm;
        longint     q;
        case (pred_mode)
            qkc_pkg::MODE_ASYM:
            begin
                if (x >= pred_lim_pos)
                begin
                    k = derive_knee(pred_lim_pos);
                    y = sat_shift(knee_up(k, x), 7);
                end
                else if (x <= pred_lim_neg)
                begin
                    k = derive_knee(sat_negate(pred_lim_neg));
                    y = sat_shift(knee_down(k, x), 7);
                end
                else
                begin
                    y = x;
                end
            end
            qkc_pkg::MODE_NORM:
            begin
                k = derive_knee(pred_lim_pos);
                q = longint'(int'(longint'(k.a) + longint'(k.b) + longint'(k.c))) >>> 20;
                if (q == 0) q = 1;
                norm = int'(FULL_POS / q);
                if (x >= pred_lim_pos)
                    y = sat_shift(frac_mul(knee_up(k, x), norm), 11);
                else if (x <= sat_negate(pred_lim_pos))
                    y = sat_shift(frac_mul(knee_down(k, x), norm), 11);
                else
                    y = sat_shift(frac_mul(x, norm), 4);
            end
            default:
            begin
                k = derive_knee(pred_lim_pos);
                if (x >= pred_lim_pos)
                    y = sat_shift(knee_up(k, x), 7);
                else if (x <= sat_negate(pred_lim_pos))
                    y = sat_shift(knee_down(k, x), 7);
                else
                    y = x;
            end
        endcase
        return y;
    endfunction

    function automatic void track_reg(logic [qkc_pkg::CFG_IDX_W-1:0] idx,
                                      logic [qkc_pkg::DATA_W-1:0] val);
        longint v;
        case (idx)
            qkc_pkg::REG_CLIP_MODE: pred_mode = val[1:0];
            qkc_pkg::REG_LIMIT_POS:
            begin
                v = val[30:0];
                if (v > KNEE_POS_CEIL) v = KNEE_POS_CEIL;
                pred_lim_pos = int'(v);
            end
            qkc_pkg::REG_LIMIT_NEG:
            begin
                v = longint'(signed'(val));
                if (v > 0) v = 0;
                if (v < KNEE_NEG_FLOOR) v = KNEE_NEG_FLOOR;
                pred_lim_neg = int'(v);
            end
            default: ;
        endcase
    endfunction

    function automatic logic [qkc_pkg::DATA_W-1:0] pick_sample();
        int off;
        off = int'($urandom_range(0, 4095)) - 2048;
        case ($urandom_range(0, 9))
            0, 1, 2: return $urandom();
            3, 4:    return pred_lim_pos + off;
            5, 6:    return ((pred_mode == qkc_pkg::MODE_ASYM) ? pred_lim_neg : -pred_lim_pos) + off;
            7:
            begin
                case ($urandom_range(0, 5))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h8000_0001;
                    3: return 32'hFFFF_FFFF;
                    4: return 32'h0000_0001;
                    default: return 32'h0000_0000;
                endcase
            end
            8:       return off;
            default: return $urandom() >> $urandom_range(0, 31);
        endcase
    endfunction

    task automatic send_sample(input logic [qkc_pkg::DATA_W-1:0] x, input logic typed,
                               input logic [qkc_pkg::DATA_W-1:0] want);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_axis_tdata  <= x;
        s_axis_tvalid <= 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        results_due.push_back(typed ? want : clip_sample(x));
        samples_sent++;
    endtask

    task automatic drain_and_release();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (results_due.size() != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [qkc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [qkc_pkg::DATA_W-1:0] val);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        track_reg(idx, val);
        reg_writes++;
        @(posedge clk);
        cfg_wen <= 1'b0;
        repeat (4) @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
    endtask

    initial
    begin : stimulus
        logic [qkc_pkg::DATA_W-1:0] lim_p;
        logic [qkc_pkg::DATA_W-1:0] lim_n;
        logic [1:0]                 mode;
        pred_mode    = qkc_pkg::MODE_SYM;
        pred_lim_pos = int'(qkc_pkg::RST_LIMIT_POS);
        pred_lim_neg = qkc_pkg::RST_LIMIT_NEG;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            if (DIRECTED_ROWS[i].kind == ROW_WRITE)
            begin
                drain_and_release();
                write_reg(DIRECTED_ROWS[i].idx, DIRECTED_ROWS[i].data);
            end
            else
            begin
                send_sample(DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].typed,
                            DIRECTED_ROWS[i].want);
            end
        end
        directed_sent = samples_sent;

        for (int p = 0; p < PHASES; p++)
        begin
            mode = (p < 4) ? p[1:0] : 2'($urandom_range(0, 3));
            case (p)
                0:
                begin
                    lim_p = 32'h0000_0000;
                    lim_n = 32'h0000_0000;
                end
                1:
                begin
                    lim_p = 32'h7EFF_FFFF;
                    lim_n = 32'h8100_0001;
                end
                2:
                begin
                    lim_p = $urandom();
                    lim_n = $urandom();
                end
                default:
                begin
                    lim_p = $urandom_range(0, 32'h7EFF_FFFF);
                    lim_n = -$urandom_range(0, 32'h7EFF_FFFF);
                end
            endcase
            drain_and_release();
            write_reg(qkc_pkg::REG_CLIP_MODE, {30'd0, mode});
            write_reg(qkc_pkg::REG_LIMIT_POS, lim_p);
            write_reg(qkc_pkg::REG_LIMIT_NEG, lim_n);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (p == 2 && n == 5) hold_wanted <= 1'b1;
                send_sample(pick_sample(), 1'b0, '0);
            end
        end

        drain_and_release();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (results_due.size() != 0) mismatches += results_due.size();
        $display("Covered %0d samples (%0d directed) across %0d register writes in all mode codes,",
                 samples_sent, directed_sent, reg_writes);
        $display("with %0d results checked and one %0d-cycle output hold-off.",
                 results_seen, HOLD_CYCLES);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin : result_sink
        int  style;
        int  style_left;
        bit  hold_served;
        style       = 0;
        style_left  = 0;
        hold_served = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_wanted && !hold_served)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_served = 1'b1;
            end
            else
            begin
                if (style_left == 0)
                begin
                    style      = $urandom_range(0, 2);
                    style_left = $urandom_range(16, 96);
                end
                style_left--;
                case (style)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
                    default: m_axis_tready <= (style_left % 4 == 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            if (results_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("Result transaction %h arrived with nothing expected", m_axis_tdata);
            end
            else if (m_axis_tdata !== results_due[0])
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("Mismatch on result %0d: sample_out expected %h, got %h",
                             results_seen, results_due[0], m_axis_tdata);
                void'(results_due.pop_front());
            end
            else
            begin
                void'(results_due.pop_front());
            end
        end
    end

    initial
    begin : watchdog
        #4_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
